// File: hdl/juesc_pkg.sv
// ----------------------------------------------------------------------------
// juesc_pkg
// Shared types for the JSON string unescaper: decode modes, status codes
// and the command word passed from the decoder to the output stage.
// ----------------------------------------------------------------------------
package juesc_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESCAPE = 3'd1,
    MODE_HEX0   = 3'd2,
    MODE_HEX1   = 3'd3,
    MODE_HEX2   = 3'd4,
    MODE_HEX3   = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_CONTROL    = 3'd1,
    ST_BADESC     = 3'd2,
    ST_BADHEX     = 3'd3,
    ST_INCOMPLETE = 3'd4
  } status_t;

  // One decoded unit of work: either one to three output bytes, or the
  // closing status of a string.
  typedef struct packed {
    logic                is_end;
    logic [1:0]          nbytes;
    logic [2:0][7:0]     bytes;
    status_t             status;
  } cmd_t;

endpackage

// File: hdl/json_string_unescaper_top.sv
// ----------------------------------------------------------------------------
// json_string_unescaper_top
// Streaming decoder for JSON string bodies with escape and \u handling.
// ----------------------------------------------------------------------------
// Send the body bytes of a string (req_type 0), then an end marker
// (req_type 1). Escapes are decoded, \uXXXX is emitted as one to three
// UTF-8 bytes (surrogates unpaired), and each end marker yields one result
// with end_flag set and the status of the string; the first error stops byte
// output until then. One input transaction is taken per cycle while the
// command queue has room; the output stage drains one result per cycle while
// out_stall is low, so a \u escape that expands to three bytes yields three results.
// QUEUE_DEPTH (2 or more) sets how far the input can run ahead of a stalled
// output.
module json_string_unescaper_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       req_type,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       end_flag,
  output logic [2:0] status
);
  import juesc_pkg::*;

  cmd_t push_cmd, head;
  logic push, full, pop, empty;

  juesc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (req_type),
    .in_byte  (in_byte),
    .q_full   (full),
    .q_push   (push),
    .q_cmd    (push_cmd)
  );

  juesc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  juesc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (empty),
    .q_head     (head),
    .q_pop      (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .end_flag   (end_flag),
    .status     (status)
  );

endmodule

// File: hdl/juesc_front.sv
// ----------------------------------------------------------------------------
// juesc_front
// Input side: accepts raw string bytes, tracks the escape state and turns
// the decoded bytes and each end marker into commands for the output queue.
// ----------------------------------------------------------------------------
module juesc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              req_type,
  input  logic [7:0]        in_byte,
  input  logic              q_full,
  output logic              q_push,
  output juesc_pkg::cmd_t   q_cmd
);
  import juesc_pkg::*;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  mode_t       mode, mode_next;
  logic [11:0] acc, acc_next;
  status_t     err, err_next;

  logic        accept;
  logic        emit;
  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] code;

  // returns {digit valid, digit value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    return r;
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept && emit;
  assign {hex_ok, hex_val} = hex_digit(in_byte);
  assign code = {acc, hex_val};

  always_comb begin
    mode_next    = mode;
    acc_next     = acc;
    err_next     = err;
    emit         = 1'b0;
    q_cmd.is_end = 1'b0;
    q_cmd.nbytes = 2'd1;
    q_cmd.bytes  = '0;
    q_cmd.status = ST_OK;
    if (req_type) begin
      emit         = 1'b1;
      q_cmd.is_end = 1'b1;
      q_cmd.nbytes = 2'd0;
      if (err != ST_OK) begin
        q_cmd.status = err;
      end else if (mode >= MODE_ESCAPE && mode <= MODE_HEX3) begin
        q_cmd.status = ST_INCOMPLETE;
      end
      mode_next = MODE_NORMAL;
      acc_next  = '0;
      err_next  = ST_OK;
    end else if (err != ST_OK) begin
      // sticky error: swallow body bytes until the end marker
    end else if (in_byte <= 8'h1F || in_byte == CH_DEL) begin
      err_next = ST_CONTROL;
    end else begin
      unique case (mode)
        MODE_ESCAPE: begin
          mode_next = MODE_NORMAL;
          emit      = 1'b1;
          unique case (in_byte)
            CH_QUOTE: q_cmd.bytes[0] = CH_QUOTE;
            CH_BSL:   q_cmd.bytes[0] = CH_BSL;
            CH_SLASH: q_cmd.bytes[0] = CH_SLASH;
            CH_B:     q_cmd.bytes[0] = 8'h08;
            CH_F:     q_cmd.bytes[0] = 8'h0C;
            CH_N:     q_cmd.bytes[0] = 8'h0A;
            CH_R:     q_cmd.bytes[0] = 8'h0D;
            CH_T:     q_cmd.bytes[0] = 8'h09;
            CH_U: begin
              emit      = 1'b0;
              mode_next = MODE_HEX0;
              acc_next  = '0;
            end
            default: begin
              emit     = 1'b0;
              err_next = ST_BADESC;
            end
          endcase
        end
        MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
          if (!hex_ok) begin
            err_next  = ST_BADHEX;
            mode_next = MODE_NORMAL;
            acc_next  = '0;
          end else if (mode != MODE_HEX3) begin
            acc_next  = {acc[7:0], hex_val};
            mode_next = mode_t'(mode + 3'd1);
          end else begin
            mode_next = MODE_NORMAL;
            acc_next  = '0;
            emit      = 1'b1;
            // UTF-8 of the code unit, surrogates encoded as-is
            if (code < 16'h0080) begin
              q_cmd.nbytes   = 2'd1;
              q_cmd.bytes[0] = code[7:0];
            end else if (code < 16'h0800) begin
              q_cmd.nbytes   = 2'd2;
              q_cmd.bytes[0] = {3'b110, code[10:6]};
              q_cmd.bytes[1] = {2'b10, code[5:0]};
            end else begin
              q_cmd.nbytes   = 2'd3;
              q_cmd.bytes[0] = {4'b1110, code[15:12]};
              q_cmd.bytes[1] = {2'b10, code[11:6]};
              q_cmd.bytes[2] = {2'b10, code[5:0]};
            end
          end
        end
        default: begin
          mode_next = MODE_NORMAL;
          if (in_byte == CH_BSL) begin
            mode_next = MODE_ESCAPE;
          end else begin
            emit           = 1'b1;
            q_cmd.bytes[0] = in_byte;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL;
      acc  <= '0;
      err  <= ST_OK;
    end else if (accept) begin
      mode <= mode_next;
      acc  <= acc_next;
      err  <= err_next;
    end
  end

endmodule

// File: hdl/juesc_queue.sv
// ----------------------------------------------------------------------------
// juesc_queue
// Small command FIFO between the decoder and the output stage.
// ----------------------------------------------------------------------------
module juesc_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  juesc_pkg::cmd_t   push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output juesc_pkg::cmd_t   head
);
  import juesc_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [IDX_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hdl/juesc_back.sv
// ----------------------------------------------------------------------------
// juesc_back
// Output side: expands queued commands into result transactions, one per
// cycle while out_stall is low, through a registered output stage.
// ----------------------------------------------------------------------------
module juesc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  juesc_pkg::cmd_t   q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              byte_valid,
  output logic              end_flag,
  output logic [2:0]        status
);
  import juesc_pkg::*;

  logic            load;
  logic [1:0][7:0] hold_bytes;
  logic [1:0]      hold_cnt;

  // output register can take a new transaction
  assign load  = !out_valid || !out_stall;
  assign q_pop = load && (hold_cnt == 2'd0) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      hold_cnt  <= '0;
    end else if (load) begin
      if (hold_cnt != 2'd0) begin
        out_valid <= 1'b1;
        hold_cnt  <= hold_cnt - 2'd1;
      end else if (!q_empty) begin
        out_valid <= 1'b1;
        hold_cnt  <= q_head.is_end ? 2'd0 : q_head.nbytes - 2'd1;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (hold_cnt != 2'd0) begin
        out_byte      <= hold_bytes[0];
        byte_valid    <= 1'b1;
        end_flag      <= 1'b0;
        status        <= ST_OK;
        hold_bytes[0] <= hold_bytes[1];
      end else if (!q_empty) begin
        out_byte      <= q_head.is_end ? 8'h00 : q_head.bytes[0];
        byte_valid    <= !q_head.is_end;
        end_flag      <= q_head.is_end;
        status        <= q_head.is_end ? q_head.status : ST_OK;
        hold_bytes[0] <= q_head.bytes[1];
        hold_bytes[1] <= q_head.bytes[2];
      end
    end
  end

endmodule
